>>> sv/cstb_pkg.sv
// shared constants and transaction types for the seconds to calendar breakdown block
package cstb_pkg;

  // width of the incoming second count
  localparam int SECONDS_BITS = 32;

  // shared subtractor width: covers a full leap year of seconds and the input count
  localparam int UNIT_W = (SECONDS_BITS > 26) ? SECONDS_BITS : 26;

  // largest year offset (2199)
  localparam logic [8:0] MAX_OFFSET = 9'd299;

  // second counts of the calendar units
  localparam logic [24:0] YEAR_SECS      = 25'd31536000;
  localparam logic [24:0] LEAP_YEAR_SECS = 25'd31622400;
  localparam logic [16:0] DAY_SECS       = 17'd86400;
  localparam logic [11:0] HOUR_SECS      = 12'd3600;
  localparam logic [5:0]  MIN_SECS       = 6'd60;

  // quotient widths of the restoring division passes
  localparam logic [3:0] YDAY_QBITS = 4'd9;
  localparam logic [3:0] HOUR_QBITS = 4'd5;
  localparam logic [3:0] MIN_QBITS  = 4'd6;

  // last month index
  localparam logic [3:0] LAST_MONTH = 4'd11;

  typedef struct packed {
    logic [8:0]              ref_year_offset;
    logic [SECONDS_BITS-1:0] seconds_since_ref;
  } in_t;

  typedef struct packed {
    logic [8:0] year_offset;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [2:0] weekday;
    logic       range_error;
  } out_t;

endpackage

>>> sv/seconds_to_calendar_breakdown.sv
// sequence: one year step per cycle for each whole year crossed, then 9 + 5 + 6 restoring division
// steps and up to 12 month steps, all on one shared subtractor
// throughput: one transaction at a time, the next is taken once the result enters the output register
// reset: synchronous active-low rst_n clears the sequencer and the output valid
module seconds_to_calendar_breakdown (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cstb_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cstb_pkg::out_t  out_data
);

  logic           busy;
  logic           res_valid;
  logic           res_take;
  cstb_pkg::out_t res;
  logic           out_valid_r, out_valid_nxt;
  cstb_pkg::out_t out_data_r, out_data_nxt;

  assign in_stall = busy;

  // output slot is free when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  cstb_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_valid),
    .start_data (in_data),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/cstb_subunit.sv
// shared subtract and compare unit used by every step of the sequencer
module cstb_subunit (
  input  logic [cstb_pkg::UNIT_W-1:0] op_a,
  input  logic [cstb_pkg::UNIT_W-1:0] op_b,
  output logic [cstb_pkg::UNIT_W-1:0] diff,
  output logic                        ge
);

  // one wide subtract, borrow gives the compare
  logic [cstb_pkg::UNIT_W:0] full_diff;

  assign full_diff = {1'b0, op_a} - {1'b0, op_b};
  assign diff      = full_diff[cstb_pkg::UNIT_W-1:0];
  assign ge        = ~full_diff[cstb_pkg::UNIT_W];

endmodule

>>> sv/cstb_core.sv
// sequencer and working registers: year walk, division passes, month walk
module cstb_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  cstb_pkg::in_t   start_data,
  output logic            busy,
  output logic            res_valid,
  input  logic            res_take,
  output cstb_pkg::out_t  res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_YEAR = 3'd1;
  localparam logic [2:0] ST_YDAY = 3'd2;
  localparam logic [2:0] ST_HOUR = 3'd3;
  localparam logic [2:0] ST_MIN  = 3'd4;
  localparam logic [2:0] ST_MON  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // gregorian leap test for offsets 0..299 from 1900
  function automatic logic leap_of(input logic [8:0] off);
    return (off[1:0] == 2'd0) && (off != 9'd0) && (off != 9'd200);
  endfunction

  // value mod 7 by folding octal digits (8 is 1 mod 7)
  function automatic logic [2:0] mod7(input logic [8:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
  endfunction

  // weekday of january 1 of year 1900 + off, 1900 was a monday
  function automatic logic [2:0] jan1_weekday(input logic [8:0] off);
    logic [8:0] leaps;
    leaps = (off == 9'd0) ? 9'd0 :
            (((off - 9'd1) >> 2) - ((off > 9'd200) ? 9'd1 : 9'd0));
    return mod7(9'd1 + off + leaps);
  endfunction

  // days in month, february stretched in leap years
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1:                       len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
      default:                    len = 5'd31;
    endcase
    return len;
  endfunction

  logic [2:0]                  state_r, state_nxt;
  logic [8:0]                  off_r, off_nxt;
  logic [cstb_pkg::UNIT_W-1:0] rem_r, rem_nxt;
  logic [2:0]                  wd_r, wd_nxt;
  logic [3:0]                  k_r, k_nxt;
  logic [8:0]                  yday_r, yday_nxt;
  logic [4:0]                  hour_r, hour_nxt;
  logic [5:0]                  min_r, min_nxt;
  logic [5:0]                  sec_r, sec_nxt;
  logic [3:0]                  mon_r, mon_nxt;
  logic                        err_r, err_nxt;

  logic [cstb_pkg::UNIT_W-1:0] op_b;
  logic [cstb_pkg::UNIT_W-1:0] diff;
  logic                        ge;
  logic                        leap;
  logic [3:0]                  wd_step;

  assign leap = leap_of(off_r);

  // divisor or subtrahend for the current step
  always_comb begin
    unique case (state_r)
      ST_YEAR: op_b = leap ? cstb_pkg::UNIT_W'(cstb_pkg::LEAP_YEAR_SECS)
                           : cstb_pkg::UNIT_W'(cstb_pkg::YEAR_SECS);
      ST_YDAY: op_b = cstb_pkg::UNIT_W'(cstb_pkg::DAY_SECS) << k_r;
      ST_HOUR: op_b = cstb_pkg::UNIT_W'(cstb_pkg::HOUR_SECS) << k_r;
      ST_MIN:  op_b = cstb_pkg::UNIT_W'(cstb_pkg::MIN_SECS) << k_r;
      ST_MON:  op_b = cstb_pkg::UNIT_W'(month_len(mon_r, leap));
      default: op_b = '0;
    endcase
  end

  cstb_subunit u_sub (
    .op_a (rem_r),
    .op_b (op_b),
    .diff (diff),
    .ge   (ge)
  );

  // weekday advance over one whole year
  assign wd_step = 4'(wd_r) + (leap ? 4'd2 : 4'd1);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    off_nxt   = off_r;
    rem_nxt   = rem_r;
    wd_nxt    = wd_r;
    k_nxt     = k_r;
    yday_nxt  = yday_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    mon_nxt   = mon_r;
    err_nxt   = err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          off_nxt   = start_data.ref_year_offset;
          rem_nxt   = cstb_pkg::UNIT_W'(start_data.seconds_since_ref);
          wd_nxt    = jan1_weekday(start_data.ref_year_offset);
          err_nxt   = start_data.ref_year_offset > cstb_pkg::MAX_OFFSET;
          state_nxt = (start_data.ref_year_offset > cstb_pkg::MAX_OFFSET) ? ST_FIN : ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          rem_nxt = diff;
          off_nxt = off_r + 9'd1;
          wd_nxt  = (wd_step >= 4'd7) ? 3'(wd_step - 4'd7) : 3'(wd_step);
          if (off_r == cstb_pkg::MAX_OFFSET) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end
        end else begin
          k_nxt     = cstb_pkg::YDAY_QBITS - 4'd1;
          state_nxt = ST_YDAY;
        end
      end
      ST_YDAY: begin
        if (ge) rem_nxt = diff;
        yday_nxt = {yday_r[7:0], ge};
        if (k_r == 4'd0) begin
          k_nxt     = cstb_pkg::HOUR_QBITS - 4'd1;
          state_nxt = ST_HOUR;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_HOUR: begin
        if (ge) rem_nxt = diff;
        hour_nxt = {hour_r[3:0], ge};
        if (k_r == 4'd0) begin
          k_nxt     = cstb_pkg::MIN_QBITS - 4'd1;
          state_nxt = ST_MIN;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_MIN: begin
        if (ge) rem_nxt = diff;
        min_nxt = {min_r[4:0], ge};
        if (k_r == 4'd0) begin
          // leftover is the second, then reuse rem for the month walk
          sec_nxt   = ge ? diff[5:0] : rem_r[5:0];
          rem_nxt   = cstb_pkg::UNIT_W'(yday_r);
          mon_nxt   = 4'd0;
          state_nxt = ST_MON;
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_MON: begin
        if ((mon_r == cstb_pkg::LAST_MONTH) || !ge) begin
          state_nxt = ST_FIN;
        end else begin
          rem_nxt = diff;
          mon_nxt = mon_r + 4'd1;
        end
      end
      ST_FIN: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    rem_r  <= rem_nxt;
    wd_r   <= wd_nxt;
    k_r    <= k_nxt;
    yday_r <= yday_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    mon_r  <= mon_nxt;
    err_r  <= err_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_FIN);

  // result assembly, all zero but the year and the error flag on a range error
  always_comb begin
    res = '0;
    if (err_r) begin
      res.year_offset = cstb_pkg::MAX_OFFSET;
      res.range_error = 1'b1;
    end else begin
      res.year_offset      = off_r;
      res.day_of_year      = yday_r;
      res.month_index      = mon_r;
      res.day_of_month     = rem_r[4:0] + 5'd1;
      res.hour_of_day      = hour_r;
      res.minute_of_hour   = min_r;
      res.second_of_minute = sec_r;
      res.weekday          = mod7(9'(wd_r) + yday_r);
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// testbench for seconds_to_calendar_breakdown: directed and random conversions checked against a behavioral calendar
module tb;

  localparam int unsigned EPOCH_YEAR = 1900;
  localparam int unsigned ONE_DAY    = 86400;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  cstb_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  cstb_pkg::out_t out_data;

  // dates predicted for accepted transactions, oldest first
  cstb_pkg::out_t expected_dates[$];
  int unsigned    fail_count  = 0;
  bit             idle_enable = 1'b1;

  seconds_to_calendar_breakdown uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // calendar helpers
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned leap_days_before(int unsigned y);
    int unsigned p;
    p = y - 1;
    return p / 4 - p / 100 + p / 400;
  endfunction

  function automatic int unsigned month_days(int unsigned m, bit lp);
    case (m)
      1:          return lp ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic longint unsigned year_secs(int unsigned off);
    return longint'(is_leap(EPOCH_YEAR + off) ? 366 : 365) * ONE_DAY;
  endfunction

  // expected breakdown of one transaction
  function automatic cstb_pkg::out_t calendar_of(cstb_pkg::in_t t);
    cstb_pkg::out_t    r;
    int unsigned       yr, rem, yday, sod, left, mon, days;
    longint unsigned   s;
    bit                err, walking, lp;
    r       = '0;
    yr      = 32'(t.ref_year_offset);
    s       = 64'(t.seconds_since_ref);
    err     = (yr > cstb_pkg::MAX_OFFSET);
    walking = !err;
    // strip whole years until the remainder fits
    while (walking) begin
      if (s < year_secs(yr)) begin
        walking = 1'b0;
      end else begin
        s  = s - year_secs(yr);
        yr = yr + 1;
        if (yr > cstb_pkg::MAX_OFFSET) begin
          err     = 1'b1;
          walking = 1'b0;
        end
      end
    end
    if (err) begin
      r.year_offset = cstb_pkg::MAX_OFFSET;
      r.range_error = 1'b1;
      return r;
    end
    rem  = 32'(s);
    yday = rem / ONE_DAY;
    sod  = rem % ONE_DAY;
    lp   = is_leap(EPOCH_YEAR + yr);
    left = yday;
    mon  = 0;
    // month walk, december takes whatever is left
    while (mon < 11 && left >= month_days(mon, lp)) begin
      left = left - month_days(mon, lp);
      mon  = mon + 1;
    end
    // january 1 1900 was a monday
    days = 365 * yr + leap_days_before(EPOCH_YEAR + yr) - leap_days_before(EPOCH_YEAR) + yday;
    r.year_offset      = 9'(yr);
    r.day_of_year      = 9'(yday);
    r.month_index      = 4'(mon);
    r.day_of_month     = 5'(left + 1);
    r.hour_of_day      = 5'(sod / 3600);
    r.minute_of_hour   = 6'((sod % 3600) / 60);
    r.second_of_minute = 6'(sod % 60);
    r.weekday          = 3'((1 + days) % 7);
    r.range_error      = 1'b0;
    return r;
  endfunction

  // random transaction, weighted toward year, month and day edges and offsets at or past the limit
  function automatic cstb_pkg::in_t random_item();
    cstb_pkg::in_t   t;
    int unsigned     pick, k, i, yday, m, off;
    bit              lp;
    longint unsigned s;
    pick                = $urandom_range(0, 9);
    t.ref_year_offset   = 9'($urandom_range(0, cstb_pkg::MAX_OFFSET));
    t.seconds_since_ref = $urandom;
    off                 = 32'(t.ref_year_offset);
    if (pick == 0) begin
      t.ref_year_offset = 9'($urandom);
    end else if (pick == 1) begin
      t.ref_year_offset = 9'($urandom_range(cstb_pkg::MAX_OFFSET + 1, 511));
    end else if (pick <= 3) begin
      t.seconds_since_ref = $urandom_range(0, cstb_pkg::LEAP_YEAR_SECS - 1);
    end else if (pick <= 7) begin
      // landmark instant: k years on, at a month start, a month end or a random day in the month
      k = $urandom_range(0, 140);
      s = 0;
      for (i = 0; i < k; i++) s = s + year_secs(off + i);
      lp   = is_leap(EPOCH_YEAR + off + k);
      m    = $urandom_range(0, 11);
      yday = 0;
      for (i = 0; i < m; i++) yday = yday + month_days(i, lp);
      case ($urandom_range(0, 2))
        0:       ;
        1:       yday = yday + month_days(m, lp) - 1;
        default: yday = yday + $urandom_range(0, month_days(m, lp) - 1);
      endcase
      s = s + longint'(yday) * ONE_DAY;
      case ($urandom_range(0, 3))
        0:       ;
        1:       s = s + ONE_DAY - 1;
        2:       if (s != 0) s = s - 1;
        default: s = s + $urandom_range(0, ONE_DAY - 1);
      endcase
      if (s <= 64'hFFFF_FFFF) t.seconds_since_ref = 32'(s);
    end else if (pick == 8) begin
      t.ref_year_offset   = 9'($urandom_range(cstb_pkg::MAX_OFFSET - 20, cstb_pkg::MAX_OFFSET));
      t.seconds_since_ref = $urandom_range(0, 700_000_000);
    end
    return t;
  endfunction

  function automatic string fmt_date(cstb_pkg::out_t d);
    return $sformatf("yr+%0d yday %0d mon %0d mday %0d %0d:%0d:%0d wd %0d err %0b",
                     d.year_offset, d.day_of_year, d.month_index, d.day_of_month,
                     d.hour_of_day, d.minute_of_hour, d.second_of_minute, d.weekday,
                     d.range_error);
  endfunction

  task automatic report_mismatch(string what, cstb_pkg::out_t want, cstb_pkg::out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s\n  expected %s\n  actual   %s", $time, what, fmt_date(want),
               fmt_date(got));
  endtask

  // drive one transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic [8:0] off,
                           input logic [cstb_pkg::SECONDS_BITS-1:0] secs);
    cstb_pkg::in_t item;
    int            gap;
    item.ref_year_offset   = off;
    item.seconds_since_ref = secs;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      repeat (gap) begin
        @(negedge clk);
        in_valid                  = 1'b0;
        in_data.ref_year_offset   = 9'($urandom);
        in_data.seconds_since_ref = $urandom;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    expected_dates.push_back(calendar_of(item));
  endtask

  task automatic send_random(int n);
    cstb_pkg::in_t t;
    repeat (n) begin
      t = random_item();
      send_item(t.ref_year_offset, t.seconds_since_ref);
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  // extremes of both fields and the calendar corner cases
  task automatic test_directed();
    send_item(9'd0,   32'd0);
    send_item(9'd299, 32'd0);
    send_item(9'd300, 32'd0);
    send_item(9'd511, 32'hFFFF_FFFF);
    send_item(9'd0,   32'hFFFF_FFFF);
    send_item(9'd299, 365 * ONE_DAY - 1);
    send_item(9'd299, 365 * ONE_DAY);
    send_item(9'd299, 32'hFFFF_FFFF);
    send_item(9'd298, 730 * ONE_DAY - 1);
    send_item(9'd298, 730 * ONE_DAY);
    send_item(9'd100, 59 * ONE_DAY);
    send_item(9'd100, 365 * ONE_DAY + ONE_DAY - 1);
    send_item(9'd0,   59 * ONE_DAY);
    send_item(9'd200, 59 * ONE_DAY);
    send_item(9'd104, 366 * ONE_DAY - 1);
    send_item(9'd0,   365 * ONE_DAY);
    send_item(9'd0,   31 * ONE_DAY - 1);
    send_item(9'd70,  32'd0);
    send_item(9'd70,  32'h7FFF_FFFF);
    send_item(9'd1,   32'h8000_0000);
    send_item(9'd256, 32'd12345678);
    send_item(9'd0,   ONE_DAY - 1);
    send_item(9'd0,   32'd3600);
    send_item(9'd0,   32'd60);
  endtask

  task automatic test_random_traffic(int n);
    send_random(n);
  endtask

  // sender holds off until every pending conversion has come back
  task automatic test_drain_pause();
    send_random(40);
    wait_for_drain();
    send_random(40);
  endtask

  // back to back traffic with no idling on either side
  task automatic test_steady_stream(int n);
    idle_enable = 1'b0;
    send_random(n);
  endtask

  // result side stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    cstb_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result with no transaction pending", '0, out_data);
      end else begin
        want = expected_dates.pop_front();
        if (out_data.year_offset      !== want.year_offset      ||
            out_data.day_of_year      !== want.day_of_year      ||
            out_data.month_index      !== want.month_index      ||
            out_data.day_of_month     !== want.day_of_month     ||
            out_data.hour_of_day      !== want.hour_of_day      ||
            out_data.minute_of_hour   !== want.minute_of_hour   ||
            out_data.second_of_minute !== want.second_of_minute ||
            out_data.weekday          !== want.weekday          ||
            out_data.range_error      !== want.range_error)
          report_mismatch("calendar mismatch", want, out_data);
      end
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_traffic(1400);
    test_drain_pause();
    test_steady_stream(450);
    wait_for_drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_dates.size() == 0) begin
      $display("** seconds_to_calendar_breakdown: PASSED **");
    end else begin
      $display("** seconds_to_calendar_breakdown: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("** seconds_to_calendar_breakdown: FAILED **");
    $finish;
  end

endmodule
